### rtl/spimhs_pkg.sv
// shared types, state codes and constants for the spi handshake master
package spimhs_pkg;

    localparam int MAX_TRANSFER = 2048;
    localparam int HEADER_LEN   = 4;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // event codes
    localparam logic [2:0] CMD_START_SEND = 3'd0;
    localparam logic [2:0] CMD_SLAVE_IRQ  = 3'd1;
    localparam logic [2:0] CMD_SPI_DONE   = 3'd2;
    localparam logic [2:0] CMD_SYNC       = 3'd3;
    localparam logic [2:0] CMD_TICK       = 3'd4;

    // master state codes
    localparam logic [3:0] ST_INIT           = 4'd0;
    localparam logic [3:0] ST_SEND_HDR       = 4'd1;
    localparam logic [3:0] ST_SEND_HDR_DONE  = 4'd2;
    localparam logic [3:0] ST_HDR_RECEIVED   = 4'd4;
    localparam logic [3:0] ST_SEND_DATA      = 4'd5;
    localparam logic [3:0] ST_SEND_DATA_DONE = 4'd6;
    localparam logic [3:0] ST_RECV_DATA      = 4'd7;
    localparam logic [3:0] ST_RECV_DATA_DONE = 4'd8;
    localparam logic [3:0] ST_SYNC           = 4'd9;
    localparam logic [3:0] ST_ERROR          = 4'd10;

    // link status codes
    localparam logic [1:0] S_OK      = 2'd0;
    localparam logic [1:0] S_ERROR   = 2'd1;
    localparam logic [1:0] S_BUSY    = 2'd2;
    localparam logic [1:0] S_TIMEOUT = 2'd3;

    // transfer sources
    localparam logic [1:0] SRC_BUFFER  = 2'd0;
    localparam logic [1:0] SRC_HEADER  = 2'd1;
    localparam logic [1:0] SRC_PAYLOAD = 2'd2;

    // response bytes
    localparam logic [7:0] RESP_HDR_ACK  = 8'd3;
    localparam logic [7:0] RESP_DATA_ACK = 8'd4;
    localparam logic [7:0] ACK_HDR_OK    = 8'd2;
    localparam logic [7:0] ACK_DATA_OK   = 8'd3;

    localparam logic [7:0] CHECKSUM_OK = 8'hFF;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 72;

    typedef struct packed {
        logic [3:0]  master_state;
        logic [1:0]  master_status;
        logic [15:0] payload_size;
        logic [15:0] wait_count;
        logic        waiting_ready;
        logic        pin_level;
    } t_ctx;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        slave_busy;
        logic [15:0] send_size;
        logic [31:0] rx_word;
    } t_event;

    typedef struct packed {
        logic [1:0]  link_status;
        logic [3:0]  link_state;
        logic        status_pin;
        logic        request_pulse;
        logic        spi_start;
        logic [11:0] spi_length;
        logic [1:0]  spi_source;
        logic [31:0] tx_first_word;
        logic [11:0] rx_length;
        logic        rx_ready;
        logic        send_rejected;
    } t_result;

    // length rounded up to whole words, kept to the 12 bit transfer field
    function automatic logic [11:0] round4(input logic [15:0] n);
        logic [16:0] s;
        s = {1'b0, n} + 17'd3;
        return {s[11:2], 2'b00};
    endfunction

endpackage

### rtl/spimhs_step.sv
// next-state and result logic for one link event
module spimhs_step (
    input  spimhs_pkg::t_ctx    i_ctx,
    input  spimhs_pkg::t_event  i_evt,
    input  logic [15:0]         i_ready_timeout,
    output spimhs_pkg::t_ctx    o_ctx,
    output spimhs_pkg::t_result o_res
);

    logic [15:0] lim;
    logic [15:0] wc_base;
    logic [15:0] wc_inc;
    logic        start_ok;
    logic        do_wait;
    logic        do_handle;
    logic        irq;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  hdr_sum;
    logic [15:0] rx_size;
    logic [7:0]  tx_lo;
    logic [7:0]  tx_hi;
    logic [7:0]  tx_ck;

    assign b0      = i_evt.rx_word[7:0];
    assign b1      = i_evt.rx_word[15:8];
    assign b2      = i_evt.rx_word[23:16];
    assign hdr_sum = b0 + b1 + b2;
    assign rx_size = {b1, b0};
    assign tx_lo   = i_ctx.payload_size[7:0];
    assign tx_hi   = i_ctx.payload_size[15:8];
    assign tx_ck   = ~(tx_lo + tx_hi);

    // a zero timeout acts as one
    assign lim = (i_ready_timeout == 16'd0) ? 16'd1 : i_ready_timeout;

    assign start_ok = (i_evt.send_size <= 16'(spimhs_pkg::MAX_TRANSFER))
                   && (i_ctx.master_status == spimhs_pkg::S_OK)
                   && !i_ctx.waiting_ready
                   && (i_ctx.master_state == spimhs_pkg::ST_INIT);

    assign wc_base = (i_evt.cmd == spimhs_pkg::CMD_START_SEND) ? 16'd0 : i_ctx.wait_count;
    assign wc_inc  = wc_base + 16'd1;

    always_comb begin
        o_ctx     = i_ctx;
        o_res     = '0;
        do_wait   = 1'b0;
        do_handle = 1'b0;
        irq       = 1'b0;

        unique case (i_evt.cmd)
            spimhs_pkg::CMD_START_SEND: begin
                if (start_ok) begin
                    o_ctx.payload_size = i_evt.send_size;
                    do_wait = 1'b1;
                end else begin
                    o_res.send_rejected = 1'b1;
                end
            end
            spimhs_pkg::CMD_SLAVE_IRQ: begin
                if (i_evt.slave_busy) begin
                    o_ctx = '0;
                end else begin
                    do_handle = 1'b1;
                    irq = 1'b1;
                end
            end
            spimhs_pkg::CMD_SPI_DONE: begin
                do_handle = (i_ctx.master_state != spimhs_pkg::ST_INIT);
            end
            spimhs_pkg::CMD_SYNC: begin
                o_ctx = '0;
                o_res.request_pulse = 1'b1;
            end
            spimhs_pkg::CMD_TICK: begin
                do_wait = i_ctx.waiting_ready;
            end
            default: begin
            end
        endcase

        // ready wait: count a busy sample, time out at the limit, or go ahead with the request
        if (do_wait) begin
            if (i_evt.slave_busy) begin
                if (wc_inc >= lim) begin
                    o_ctx.waiting_ready = 1'b0;
                    o_ctx.wait_count = 16'd0;
                    o_ctx.master_status = spimhs_pkg::S_TIMEOUT;
                end else begin
                    o_ctx.waiting_ready = 1'b1;
                    o_ctx.wait_count = wc_inc;
                    o_ctx.master_status = spimhs_pkg::S_BUSY;
                end
            end else begin
                o_ctx.waiting_ready = 1'b0;
                o_ctx.wait_count = 16'd0;
                o_ctx.master_state = spimhs_pkg::ST_SEND_HDR;
                o_ctx.master_status = spimhs_pkg::S_BUSY;
                o_res.request_pulse = 1'b1;
            end
        end

        if (do_handle) begin
            unique case (i_ctx.master_state)
                spimhs_pkg::ST_INIT: begin
                    if (irq && !i_ctx.waiting_ready) begin
                        o_ctx.master_state = spimhs_pkg::ST_HDR_RECEIVED;
                        o_ctx.master_status = spimhs_pkg::S_BUSY;
                        o_ctx.pin_level = 1'b1;
                        o_res.spi_start = 1'b1;
                        o_res.spi_length = spimhs_pkg::round4(16'(spimhs_pkg::HEADER_LEN));
                        o_res.spi_source = spimhs_pkg::SRC_BUFFER;
                        o_res.tx_first_word = {24'd0, spimhs_pkg::RESP_HDR_ACK};
                    end
                end
                spimhs_pkg::ST_SEND_HDR: begin
                    o_ctx.pin_level = 1'b1;
                    if (irq) begin
                        o_ctx.master_state = spimhs_pkg::ST_SEND_HDR_DONE;
                        o_res.spi_start = 1'b1;
                        o_res.spi_length = spimhs_pkg::round4(16'(spimhs_pkg::HEADER_LEN));
                        o_res.spi_source = spimhs_pkg::SRC_HEADER;
                        o_res.tx_first_word = {8'd0, tx_ck, tx_hi, tx_lo};
                    end
                end
                spimhs_pkg::ST_HDR_RECEIVED: begin
                    if (hdr_sum == spimhs_pkg::CHECKSUM_OK
                        && rx_size <= 16'(spimhs_pkg::MAX_TRANSFER)) begin
                        o_ctx.payload_size = rx_size;
                        o_ctx.master_state = spimhs_pkg::ST_RECV_DATA;
                    end else begin
                        o_ctx.master_state = spimhs_pkg::ST_ERROR;
                        o_ctx.master_status = spimhs_pkg::S_ERROR;
                    end
                    o_ctx.pin_level = 1'b0;
                end
                spimhs_pkg::ST_RECV_DATA: begin
                    if (irq) begin
                        o_ctx.pin_level = 1'b1;
                        o_ctx.master_state = spimhs_pkg::ST_RECV_DATA_DONE;
                        o_res.spi_start = 1'b1;
                        o_res.spi_length = spimhs_pkg::round4(i_ctx.payload_size);
                        o_res.spi_source = spimhs_pkg::SRC_BUFFER;
                        o_res.tx_first_word = {24'd0, spimhs_pkg::RESP_DATA_ACK};
                    end
                end
                spimhs_pkg::ST_RECV_DATA_DONE: begin
                    o_ctx.master_state = spimhs_pkg::ST_INIT;
                    o_ctx.master_status = spimhs_pkg::S_OK;
                    o_ctx.pin_level = 1'b0;
                    o_res.rx_ready = 1'b1;
                    o_res.rx_length = i_ctx.payload_size[11:0];
                end
                spimhs_pkg::ST_SEND_HDR_DONE: begin
                    if (b0 == spimhs_pkg::ACK_HDR_OK) begin
                        o_ctx.master_state = spimhs_pkg::ST_SEND_DATA;
                        o_ctx.pin_level = 1'b0;
                    end else begin
                        o_ctx.master_state = spimhs_pkg::ST_ERROR;
                        o_ctx.master_status = spimhs_pkg::S_ERROR;
                        o_ctx.pin_level = 1'b1;
                    end
                end
                spimhs_pkg::ST_SEND_DATA: begin
                    o_ctx.pin_level = 1'b1;
                    if (irq) begin
                        o_ctx.master_state = spimhs_pkg::ST_SEND_DATA_DONE;
                        o_res.spi_start = 1'b1;
                        o_res.spi_length = spimhs_pkg::round4(i_ctx.payload_size);
                        o_res.spi_source = spimhs_pkg::SRC_PAYLOAD;
                    end
                end
                spimhs_pkg::ST_SEND_DATA_DONE: begin
                    if (b0 == spimhs_pkg::ACK_DATA_OK) begin
                        o_ctx.master_state = spimhs_pkg::ST_INIT;
                        o_ctx.master_status = spimhs_pkg::S_OK;
                        o_ctx.pin_level = 1'b0;
                    end else begin
                        o_ctx.master_state = spimhs_pkg::ST_ERROR;
                        o_ctx.master_status = spimhs_pkg::S_ERROR;
                        o_ctx.pin_level = 1'b1;
                    end
                end
                spimhs_pkg::ST_SYNC: begin
                    o_ctx = '0;
                    o_res.request_pulse = 1'b1;
                end
                default: begin
                    // error state and undefined codes
                    o_ctx.master_state = spimhs_pkg::ST_ERROR;
                    o_ctx.master_status = spimhs_pkg::S_ERROR;
                    o_ctx.pin_level = 1'b1;
                end
            endcase
        end

        o_res.link_status = o_ctx.master_status;
        o_res.link_state  = o_ctx.master_state;
        o_res.status_pin  = o_ctx.pin_level;
    end

endmodule

### rtl/spi_ipc_master_handshake_fsm_top.sv
// top level of the spi handshake master: event stream in, result stream out
//
// Takes one event per clock while the output is not stalled and gives one
// result per event, in order. An accepted event lands in an input register;
// when the output register is free or draining, the link state is updated
// and the result is written to the output register. The sustained rate of
// one event per cycle is set by the single pass of next-state logic between
// the two registers. While the output is stalled the input register holds
// one more event and then the input stalls too. The ready timeout register
// sits at byte address 0 and is meant to be written while no event is in
// flight.
module spi_ipc_master_handshake_fsm_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // event stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: slave_busy[0], send_size[16:1], rx_word[48:17], zero pad[55:49]
    input  logic [spimhs_pkg::IN_TDATA_W-1:0] i_s_tdata,
    // tuser: cmd[2:0]
    input  logic [2:0]  i_s_tuser,
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: link_status[1:0], link_state[5:2], status_pin[6], request_pulse[7],
    // spi_start[8], spi_length[20:9], spi_source[22:21], tx_first_word[54:23],
    // rx_length[66:55], rx_ready[67], send_rejected[68], zero pad[71:69]
    output logic [spimhs_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    logic [15:0]         r_ready_timeout;
    logic                r_in_valid;
    spimhs_pkg::t_event  r_in;
    logic                r_out_valid;
    spimhs_pkg::t_result r_out;
    spimhs_pkg::t_ctx    r_ctx;

    spimhs_pkg::t_ctx    n_ctx;
    spimhs_pkg::t_result n_out;

    logic advance;
    logic accept;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_ready_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_timeout <= spimhs_pkg::TIMEOUT_RESET;
        end else if (cfg_wr) begin
            r_ready_timeout <= pwdata[15:0];
        end
    end

    // event moves to the result register when that register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign accept     = i_s_tvalid && o_s_tready;

    spimhs_step u_step (
        .i_ctx           (r_ctx),
        .i_evt           (r_in),
        .i_ready_timeout (r_ready_timeout),
        .o_ctx           (n_ctx),
        .o_res           (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctx       <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctx       <= n_ctx;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.cmd        <= i_s_tuser;
            r_in.slave_busy <= i_s_tdata[0];
            r_in.send_size  <= i_s_tdata[16:1];
            r_in.rx_word    <= i_s_tdata[48:17];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0,
                         r_out.send_rejected,
                         r_out.rx_ready,
                         r_out.rx_length,
                         r_out.tx_first_word,
                         r_out.spi_source,
                         r_out.spi_length,
                         r_out.spi_start,
                         r_out.request_pulse,
                         r_out.status_pin,
                         r_out.link_state,
                         r_out.link_status};

endmodule

### dv/tb_spi_ipc_master_handshake_fsm_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the spi handshake master: event stream in, link results out
module tb_spi_ipc_master_handshake_fsm_top;
    import spimhs_pkg::*;

    localparam int         CLK_HALF          = 4;
    localparam int         CYCLE_LIMIT       = 400000;
    localparam int         PRINT_CAP         = 40;
    localparam logic [2:0] REG_READY_TIMEOUT = 3'd0;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   psel       = 1'b0;
    logic                   penable    = 1'b0;
    logic                   pwrite     = 1'b0;
    logic [2:0]             paddr      = '0;
    logic [31:0]            pwdata     = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic [2:0]             i_s_tuser  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    spi_ipc_master_handshake_fsm_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // link model state
    logic [15:0] lk_timeout;
    logic [3:0]  lk_state;
    logic [1:0]  lk_status;
    logic [15:0] lk_size;
    logic [15:0] lk_wait_cnt;
    logic        lk_waiting;
    logic        lk_pin;

    t_result link_expect_q[$];
    t_result got_r;
    t_result want_r;

    int n_events    = 0;
    int n_rejects   = 0;
    int n_transfers = 0;
    int n_payloads  = 0;
    int n_timeouts  = 0;
    int n_settings  = 0;
    int n_results   = 0;
    int n_errors    = 0;
    int cycle_count = 0;

    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int hold_request = 0;
    int hold_left    = 0;

    task automatic flag_mismatch(input string msg);
        n_errors++;
        if (n_errors <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                    n_results, name, got, want));
    endtask

    function automatic void clear_link();
        lk_state    = ST_INIT;
        lk_status   = S_OK;
        lk_size     = '0;
        lk_wait_cnt = '0;
        lk_waiting  = 1'b0;
        lk_pin      = 1'b0;
    endfunction

    function automatic logic [11:0] word_align(input logic [15:0] n);
        logic [31:0] t;
        t = (32'(n) + 32'd3) & ~32'd3;
        return t[11:0];
    endfunction

    function automatic void start_xfer(inout t_result r, input logic [15:0] len,
                                       input logic [1:0] src, input logic [31:0] word);
        r.spi_start     = 1'b1;
        r.spi_length    = word_align(len);
        r.spi_source    = src;
        r.tx_first_word = word;
        n_transfers++;
    endfunction

    function automatic void launch_send(inout t_result r);
        lk_waiting    = 1'b0;
        lk_wait_cnt   = '0;
        lk_state      = ST_SEND_HDR;
        lk_status     = S_BUSY;
        r.request_pulse = 1'b1;
    endfunction

    // one more busy sample of the slave status pin during a ready wait
    function automatic void note_busy();
        logic [15:0] lim;
        lim = (lk_timeout == 16'd0) ? 16'd1 : lk_timeout;
        lk_wait_cnt = lk_wait_cnt + 16'd1;
        if (lk_wait_cnt >= lim) begin
            lk_waiting  = 1'b0;
            lk_wait_cnt = '0;
            lk_status   = S_TIMEOUT;
            n_timeouts++;
        end else begin
            lk_waiting = 1'b1;
            lk_status  = S_BUSY;
        end
    endfunction

    // slave interrupt (irq=1) or spi done (irq=0) seen by the link state machine
    function automatic void advance_state(input logic irq, input logic [31:0] rx,
                                          inout t_result r);
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  ck;
        logic [7:0]  hsum;
        logic [15:0] hsize;
        case (lk_state)
            ST_INIT: begin
                if (irq && !lk_waiting) begin
                    lk_state  = ST_HDR_RECEIVED;
                    lk_status = S_BUSY;
                    lk_pin    = 1'b1;
                    start_xfer(r, 16'(HEADER_LEN), SRC_BUFFER, {24'd0, RESP_HDR_ACK});
                end
            end
            ST_SEND_HDR: begin
                lk_pin = 1'b1;
                if (irq) begin
                    lo = lk_size[7:0];
                    hi = lk_size[15:8];
                    ck = ~(lo + hi);
                    lk_state = ST_SEND_HDR_DONE;
                    start_xfer(r, 16'(HEADER_LEN), SRC_HEADER, {8'h00, ck, hi, lo});
                end
            end
            ST_HDR_RECEIVED: begin
                hsum  = rx[7:0] + rx[15:8] + rx[23:16];
                hsize = rx[15:0];
                if (hsum == CHECKSUM_OK && hsize <= 16'(MAX_TRANSFER)) begin
                    lk_size  = hsize;
                    lk_state = ST_RECV_DATA;
                end else begin
                    lk_state  = ST_ERROR;
                    lk_status = S_ERROR;
                end
                lk_pin = 1'b0;
            end
            ST_RECV_DATA: begin
                if (irq) begin
                    lk_pin   = 1'b1;
                    lk_state = ST_RECV_DATA_DONE;
                    start_xfer(r, lk_size, SRC_BUFFER, {24'd0, RESP_DATA_ACK});
                end
            end
            ST_RECV_DATA_DONE: begin
                lk_state    = ST_INIT;
                lk_status   = S_OK;
                r.rx_ready  = 1'b1;
                r.rx_length = lk_size[11:0];
                lk_pin      = 1'b0;
                n_payloads++;
            end
            ST_SEND_HDR_DONE: begin
                if (rx[7:0] == ACK_HDR_OK) begin
                    lk_state = ST_SEND_DATA;
                    lk_pin   = 1'b0;
                end else begin
                    lk_state  = ST_ERROR;
                    lk_status = S_ERROR;
                    lk_pin    = 1'b1;
                end
            end
            ST_SEND_DATA: begin
                lk_pin = 1'b1;
                if (irq) begin
                    lk_state = ST_SEND_DATA_DONE;
                    start_xfer(r, lk_size, SRC_PAYLOAD, 32'd0);
                end
            end
            ST_SEND_DATA_DONE: begin
                if (rx[7:0] == ACK_DATA_OK) begin
                    lk_state  = ST_INIT;
                    lk_status = S_OK;
                    lk_pin    = 1'b0;
                end else begin
                    lk_state  = ST_ERROR;
                    lk_status = S_ERROR;
                    lk_pin    = 1'b1;
                end
            end
            ST_ERROR: begin
                lk_status = S_ERROR;
                lk_pin    = 1'b1;
            end
            ST_SYNC: begin
                clear_link();
                r.request_pulse = 1'b1;
            end
            default: begin
                lk_state  = ST_ERROR;
                lk_status = S_ERROR;
                lk_pin    = 1'b1;
            end
        endcase
    endfunction

    function automatic t_result predict_result(input t_event ev);
        t_result r;
        r = '0;
        case (ev.cmd)
            CMD_START_SEND: begin
                if (ev.send_size > 16'(MAX_TRANSFER) || lk_status != S_OK ||
                    lk_waiting || lk_state != ST_INIT) begin
                    r.send_rejected = 1'b1;
                    n_rejects++;
                end else begin
                    lk_size     = ev.send_size;
                    lk_wait_cnt = '0;
                    if (ev.slave_busy) note_busy();
                    else launch_send(r);
                end
            end
            CMD_SLAVE_IRQ: begin
                if (ev.slave_busy) clear_link();
                else advance_state(1'b1, ev.rx_word, r);
            end
            CMD_SPI_DONE: begin
                if (lk_state != ST_INIT) advance_state(1'b0, ev.rx_word, r);
            end
            CMD_SYNC: begin
                clear_link();
                r.request_pulse = 1'b1;
            end
            CMD_TICK: begin
                if (lk_waiting) begin
                    if (ev.slave_busy) note_busy();
                    else launch_send(r);
                end
            end
            default: ;
        endcase
        r.link_status = lk_status;
        r.link_state  = lk_state;
        r.status_pin  = lk_pin;
        return r;
    endfunction

    // offer one request, with a random gap in front of it, and log its expected result
    task automatic fire(input logic [2:0] cmd, input logic busy, input logic [15:0] size,
                        input logic [31:0] rx);
        t_event ev;
        int     gap;
        ev.cmd        = cmd;
        ev.slave_busy = busy;
        ev.send_size  = size;
        ev.rx_word    = rx;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < tx_gap_pct) gap++;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, rx, size, busy};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        link_expect_q.push_back(predict_result(ev));
        n_events++;
    endtask

    // sender goes quiet until every result is back
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (link_expect_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_timeout(input logic [15:0] val);
        logic [31:0] rd;
        apb_access(1'b1, REG_READY_TIMEOUT, {16'd0, val}, rd);
        lk_timeout = val;
        n_settings++;
        @(posedge i_clk);
        apb_access(1'b0, REG_READY_TIMEOUT, 32'd0, rd);
        if (rd[15:0] !== val)
            flag_mismatch($sformatf("ready_timeout readback 0x%0h, wrote 0x%0h", rd[15:0], val));
        @(posedge i_clk);
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_gap_pct   = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    function automatic logic [15:0] pick_size();
        int p;
        p = $urandom_range(99);
        if (p < 60) return 16'($urandom_range(64));
        else if (p < 78) return 16'($urandom_range(MAX_TRANSFER));
        else if (p < 84) return 16'(MAX_TRANSFER);
        else if (p < 90) return 16'($urandom_range(65535, MAX_TRANSFER + 1));
        else return 16'($urandom);
    endfunction

    // mostly the request the current link state is waiting for, some noise mixed in
    task automatic run_traffic(input int count);
        logic [15:0] sz;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [31:0] rx;
        int          pick;
        repeat (count) begin
            rx   = $urandom;
            pick = $urandom_range(99);
            if (pick < 8) begin
                fire(3'($urandom_range(4)), 1'($urandom_range(1)), 16'($urandom), rx);
            end else begin
                case (lk_state)
                    ST_INIT: begin
                        if (lk_waiting)
                            fire(CMD_TICK, $urandom_range(99) < 65, 16'($urandom), rx);
                        else if (lk_status != S_OK)
                            fire(pick < 80 ? CMD_SYNC : CMD_SLAVE_IRQ, 1'b1, 16'($urandom), rx);
                        else if (pick < 55)
                            fire(CMD_START_SEND, $urandom_range(99) < 30, pick_size(), rx);
                        else if (pick < 95)
                            fire(CMD_SLAVE_IRQ, 1'b0, 16'($urandom), rx);
                        else
                            fire(CMD_TICK, 1'($urandom_range(1)), 16'($urandom), rx);
                    end
                    ST_SEND_HDR, ST_SEND_DATA, ST_RECV_DATA: begin
                        fire(CMD_SLAVE_IRQ, 1'b0, 16'($urandom), rx);
                    end
                    ST_SEND_HDR_DONE: begin
                        if ($urandom_range(9) != 0) rx[7:0] = ACK_HDR_OK;
                        fire(pick < 80 ? CMD_SPI_DONE : CMD_SLAVE_IRQ, 1'b0, 16'($urandom), rx);
                    end
                    ST_SEND_DATA_DONE: begin
                        if ($urandom_range(9) != 0) rx[7:0] = ACK_DATA_OK;
                        fire(pick < 80 ? CMD_SPI_DONE : CMD_SLAVE_IRQ, 1'b0, 16'($urandom), rx);
                    end
                    ST_HDR_RECEIVED: begin
                        sz = pick_size();
                        b0 = sz[7:0];
                        b1 = sz[15:8];
                        b2 = 8'hFF - b0 - b1;
                        if ($urandom_range(9) == 0) b2 = b2 + 8'($urandom_range(255, 1));
                        rx[23:0] = {b2, b1, b0};
                        fire(pick < 80 ? CMD_SPI_DONE : CMD_SLAVE_IRQ, 1'b0, 16'($urandom), rx);
                    end
                    ST_RECV_DATA_DONE: begin
                        fire(pick < 80 ? CMD_SPI_DONE : CMD_SLAVE_IRQ, 1'b0, 16'($urandom), rx);
                    end
                    default: begin
                        fire(pick < 70 ? CMD_SYNC : CMD_SLAVE_IRQ, 1'b1, 16'($urandom), rx);
                    end
                endcase
            end
        end
    endtask

    task automatic test_directed();
        set_idling(0, 0);
        fire(CMD_START_SEND, 1'b0, 16'(MAX_TRANSFER + 1), 32'd0);
        // full send of the largest payload
        fire(CMD_START_SEND, 1'b0, 16'(MAX_TRANSFER), 32'hFFFF_FFFF);
        fire(CMD_SPI_DONE,   1'b0, 16'd0, 32'h0000_0000);
        fire(CMD_SLAVE_IRQ,  1'b0, 16'd0, 32'h5555_5555);
        fire(CMD_SPI_DONE,   1'b0, 16'd0, 32'h1234_5602);
        fire(CMD_SLAVE_IRQ,  1'b0, 16'd0, 32'hAAAA_AAAA);
        fire(CMD_SPI_DONE,   1'b0, 16'hFFFF, 32'hDEAD_BE03);
        // ready wait: stray interrupt ignored, second send refused, tick proceeds
        fire(CMD_START_SEND, 1'b1, 16'd1, 32'd0);
        fire(CMD_SLAVE_IRQ,  1'b0, 16'd0, 32'd0);
        fire(CMD_START_SEND, 1'b0, 16'd5, 32'd0);
        fire(CMD_TICK,       1'b1, 16'd0, 32'd0);
        fire(CMD_TICK,       1'b0, 16'd0, 32'd0);
        fire(CMD_SLAVE_IRQ,  1'b1, 16'd0, 32'd0);
        fire(CMD_SPI_DONE,   1'b0, 16'd0, 32'hFFFF_FFFF);
        fire(CMD_TICK,       1'b1, 16'd0, 32'd0);
        // oversized header, then bad checksum
        fire(CMD_SLAVE_IRQ,  1'b0, 16'd0, 32'd0);
        fire(CMD_SPI_DONE,   1'b0, 16'd0, 32'h00F6_0801);
        fire(CMD_SPI_DONE,   1'b0, 16'd0, 32'd0);
        fire(CMD_SYNC,       1'b0, 16'd0, 32'd0);
        fire(CMD_SLAVE_IRQ,  1'b0, 16'd0, 32'd0);
        fire(CMD_SPI_DONE,   1'b0, 16'd0, 32'h0000_0800);
        fire(CMD_SLAVE_IRQ,  1'b1, 16'd0, 32'd0);
        // full receive of the largest payload
        fire(CMD_SLAVE_IRQ,  1'b0, 16'd0, 32'd0);
        fire(CMD_SPI_DONE,   1'b0, 16'd0, 32'hAAF7_0800);
        fire(CMD_SLAVE_IRQ,  1'b0, 16'd0, 32'd0);
        fire(CMD_SPI_DONE,   1'b0, 16'd0, 32'h0123_4567);
        settle();
    endtask

    task automatic test_timeout_extremes();
        set_timeout(16'd1);
        fire(CMD_START_SEND, 1'b1, 16'd8, 32'd0);
        fire(CMD_START_SEND, 1'b0, 16'd8, 32'd0);
        fire(CMD_SYNC,       1'b0, 16'd0, 32'd0);
        run_traffic(150);
        settle();
        set_timeout(16'hFFFF);
        set_idling(46, 0);
        run_traffic(150);
        settle();
    endtask

    task automatic test_idle_phases();
        int          tx_pcts[4];
        int          rx_pcts[4];
        logic [15:0] limits[4];
        tx_pcts = '{0, 46, 0, 24};
        rx_pcts = '{0, 0, 46, 24};
        limits  = '{16'd3, TIMEOUT_RESET, 16'($urandom_range(40, 2)), 16'd7};
        for (int i = 0; i < 4; i++) begin
            set_timeout(limits[i]);
            set_idling(tx_pcts[i], rx_pcts[i]);
            run_traffic(200);
            settle();
        end
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        hold_request = 300;
        run_traffic(100);
        settle();
    endtask

    // result side: random stalls, or a long hold when one is requested
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_r.link_status   = o_m_tdata[1:0];
            got_r.link_state    = o_m_tdata[5:2];
            got_r.status_pin    = o_m_tdata[6];
            got_r.request_pulse = o_m_tdata[7];
            got_r.spi_start     = o_m_tdata[8];
            got_r.spi_length    = o_m_tdata[20:9];
            got_r.spi_source    = o_m_tdata[22:21];
            got_r.tx_first_word = o_m_tdata[54:23];
            got_r.rx_length     = o_m_tdata[66:55];
            got_r.rx_ready      = o_m_tdata[67];
            got_r.send_rejected = o_m_tdata[68];
            n_results++;
            if (link_expect_q.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with none expected", n_results));
            end else begin
                want_r = link_expect_q.pop_front();
                check_field("link_status",   32'(got_r.link_status),   32'(want_r.link_status));
                check_field("link_state",    32'(got_r.link_state),    32'(want_r.link_state));
                check_field("status_pin",    32'(got_r.status_pin),    32'(want_r.status_pin));
                check_field("request_pulse", 32'(got_r.request_pulse),
                            32'(want_r.request_pulse));
                check_field("spi_start",     32'(got_r.spi_start),     32'(want_r.spi_start));
                check_field("spi_length",    32'(got_r.spi_length),    32'(want_r.spi_length));
                check_field("spi_source",    32'(got_r.spi_source),    32'(want_r.spi_source));
                check_field("tx_first_word", got_r.tx_first_word,      want_r.tx_first_word);
                check_field("rx_length",     32'(got_r.rx_length),     32'(want_r.rx_length));
                check_field("rx_ready",      32'(got_r.rx_ready),      32'(want_r.rx_ready));
                check_field("send_rejected", 32'(got_r.send_rejected),
                            32'(want_r.send_rejected));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, link_expect_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        clear_link();
        lk_timeout = TIMEOUT_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_timeout_extremes();
        test_idle_phases();
        test_backpressure();
        $display("%0d events checked over %0d ready_timeout settings, %0d mismatches",
                 n_events, n_settings, n_errors);
        $display("%0d spi transfers, %0d payloads received, %0d refused sends, %0d ready timeouts",
                 n_transfers, n_payloads, n_rejects, n_timeouts);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
